// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/dlr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlr_pkg
// shared types and constants of the dda line rasteriser
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int SCREEN_W_DEF  = 640;
    localparam int SCREEN_H_DEF  = 480;
    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 12;
    localparam int DEPTH_W = 24;
    localparam int RED_W   = 8;
    // depth carries 8 fraction bits of its own
    localparam int DEPTH_FRAC = 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_ADD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic none;
        logic last;
        logic shade;
    } t_out_ctrl;

endpackage

// ----- hdl/dda_line_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// dda line stepper with depth shading, bit-serial datapath
// ----------------------------------------------------------------------------
// A start transfer (opcode start) loads both endpoints, sets the step count to
// max(|dx|,|dy|), divides each of dx, dy and dz by it to get signed
// fixed-point increments and returns the first pixel. Each advance transfer
// adds the increments and returns the next pixel, with last set on the final
// one; an advance with no line active returns a result with valid_res low and
// all other fields zero. A start transfer is accepted, runs the three
// bit-serial restoring dividers, one quotient bit each per cycle, and then
// loads the output register. In an advance transfer the bit-serial
// accumulators add one bit per cycle across the FRAC_BITS+24 bit word.
// A zero-length start and an advance with no line active go straight to
// the output state. A new item is accepted while the previous result
// still waits in the output register. shade_by_depth is written through
// i_cfg_we/i_cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_line_rasterizer_top
    import dlr_pkg::*;
#(
    parameter int SCREEN_W  = SCREEN_W_DEF,
    parameter int SCREEN_H  = SCREEN_H_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    // input channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_opcode,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [DEPTH_W-1:0] i_start_depth,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic signed [DEPTH_W-1:0] i_end_depth,
    // output channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_valid_res,
    output logic signed [COORD_W-1:0] o_pixel_x,
    output logic signed [COORD_W-1:0] o_pixel_y,
    output logic                      o_visible,
    output logic        [RED_W-1:0]   o_red,
    output logic                      o_last
);

    // serial word: depth accumulator width, x and y ride sign-extended in it
    localparam int SW    = FRAC_BITS + DEPTH_W;
    localparam int CNT_W = $clog2(SW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SW - 1);
    localparam int XPAD  = SW - COORD_W - FRAC_BITS;

    // control state
    t_state             r_state,      n_state;
    logic [CNT_W-1:0]   r_cnt,        n_cnt;
    logic [COORD_W-1:0] r_steps_left, n_steps_left;
    logic [COORD_W-1:0] r_steps,      n_steps;
    logic               r_start,      n_start;
    logic               r_none,       n_none;
    logic               r_last,       n_last;
    logic               r_shade;
    // increment signs, applied when the quotients are loaded
    logic               r_neg_x,      n_neg_x;
    logic               r_neg_y,      n_neg_y;
    logic               r_neg_z,      n_neg_z;

    // endpoint deltas
    logic [COORD_W:0]   w_dx;
    logic [COORD_W:0]   w_dy;
    logic [DEPTH_W:0]   w_dz;
    logic [COORD_W:0]   w_ax_full;
    logic [COORD_W:0]   w_ay_full;
    logic [DEPTH_W:0]   w_az_full;
    logic [COORD_W-1:0] w_ax;
    logic [COORD_W-1:0] w_ay;
    logic [DEPTH_W-1:0] w_az;
    logic [COORD_W-1:0] w_max;

    logic               w_in_xfer;
    logic               w_acc_load;
    logic               w_div_shift;
    logic               w_add_shift;
    logic               w_inc_load;
    logic               w_first;
    logic               w_out_free;
    t_out_ctrl          w_out_ctrl;

    logic [SW-1:0]      w_quo_x;
    logic [SW-1:0]      w_quo_y;
    logic [SW-1:0]      w_quo_z;
    logic [SW-1:0]      w_acc_x;
    logic [SW-1:0]      w_acc_y;
    logic [SW-1:0]      w_acc_z;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_xfer = i_valid && o_ready;

    // deltas and magnitudes, narrow parallel logic at accept time
    assign w_dx = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
    assign w_dy = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
    assign w_dz = {i_end_depth[DEPTH_W-1], i_end_depth}
                - {i_start_depth[DEPTH_W-1], i_start_depth};
    assign w_ax_full = w_dx[COORD_W] ? (~w_dx + 1'b1) : w_dx;
    assign w_ay_full = w_dy[COORD_W] ? (~w_dy + 1'b1) : w_dy;
    assign w_az_full = w_dz[DEPTH_W] ? (~w_dz + 1'b1) : w_dz;
    assign w_ax  = w_ax_full[COORD_W-1:0];
    assign w_ay  = w_ay_full[COORD_W-1:0];
    assign w_az  = w_az_full[DEPTH_W-1:0];
    assign w_max = (w_ax > w_ay) ? w_ax : w_ay;

    // datapath strobes
    assign w_acc_load  = w_in_xfer && (i_opcode == OP_START);
    assign w_div_shift = (r_state == S_DIV);
    assign w_add_shift = (r_state == S_ADD);
    assign w_first     = (r_cnt == '0);
    // quotients are settled once the divide pass is over
    assign w_inc_load  = (r_state == S_OUT) && r_start;

    assign w_out_ctrl.load  = (r_state == S_OUT) && w_out_free;
    assign w_out_ctrl.none  = r_none;
    assign w_out_ctrl.last  = r_last;
    assign w_out_ctrl.shade = r_shade;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_steps_left = r_steps_left;
        n_steps      = r_steps;
        n_start      = r_start;
        n_none       = r_none;
        n_last       = r_last;
        n_neg_x      = r_neg_x;
        n_neg_y      = r_neg_y;
        n_neg_z      = r_neg_z;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cnt = '0;
                    if (i_opcode == OP_START) begin
                        // a start drops any line in progress
                        n_start      = 1'b1;
                        n_none       = 1'b0;
                        n_steps      = w_max;
                        n_steps_left = w_max;
                        n_last       = (w_max == '0);
                        n_neg_x      = w_dx[COORD_W];
                        n_neg_y      = w_dy[COORD_W];
                        n_neg_z      = w_dz[DEPTH_W];
                        n_state      = (w_max == '0) ? S_OUT : S_DIV;
                    end else if (r_steps_left == '0) begin
                        // advance with no line active
                        n_start = 1'b0;
                        n_none  = 1'b1;
                        n_last  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_start      = 1'b0;
                        n_none       = 1'b0;
                        n_last       = (r_steps_left == COORD_W'(1));
                        n_steps_left = r_steps_left - 1'b1;
                        n_state      = S_ADD;
                    end
                end
            end
            S_DIV, S_ADD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_steps_left <= '0;
            r_start      <= 1'b0;
            r_none       <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_steps_left <= n_steps_left;
            r_start      <= n_start;
            r_none       <= n_none;
            r_last       <= n_last;
        end
    end

    // payload side of the sequencer
    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_neg_z <= n_neg_z;
    end

    // shade_by_depth register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shade <= 1'b1;
        end else if (i_cfg_we) begin
            r_shade <= i_cfg_wdata;
        end
    end

    // increment dividers: (|delta| << FRAC_BITS) / steps
    dlr_serial_div #(.SW(SW)) u_div_x (
        .i_clk      (i_clk),
        .i_load     (w_acc_load),
        .i_shift    (w_div_shift),
        .i_dividend ({{XPAD{1'b0}}, w_ax, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_steps),
        .o_quotient (w_quo_x)
    );

    dlr_serial_div #(.SW(SW)) u_div_y (
        .i_clk      (i_clk),
        .i_load     (w_acc_load),
        .i_shift    (w_div_shift),
        .i_dividend ({{XPAD{1'b0}}, w_ay, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_steps),
        .o_quotient (w_quo_y)
    );

    dlr_serial_div #(.SW(SW)) u_div_z (
        .i_clk      (i_clk),
        .i_load     (w_acc_load),
        .i_shift    (w_div_shift),
        .i_dividend ({w_az, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_steps),
        .o_quotient (w_quo_z)
    );

    // accumulators, loaded with the start point scaled by FRAC_BITS
    dlr_serial_acc #(.SW(SW)) u_acc_x (
        .i_clk      (i_clk),
        .i_load_acc (w_acc_load),
        .i_acc_init ({{XPAD{i_start_x[COORD_W-1]}}, i_start_x, {FRAC_BITS{1'b0}}}),
        .i_load_inc (w_inc_load),
        .i_inc_mag  (w_quo_x),
        .i_inc_neg  (r_neg_x),
        .i_shift    (w_add_shift),
        .i_first    (w_first),
        .o_acc      (w_acc_x)
    );

    dlr_serial_acc #(.SW(SW)) u_acc_y (
        .i_clk      (i_clk),
        .i_load_acc (w_acc_load),
        .i_acc_init ({{XPAD{i_start_y[COORD_W-1]}}, i_start_y, {FRAC_BITS{1'b0}}}),
        .i_load_inc (w_inc_load),
        .i_inc_mag  (w_quo_y),
        .i_inc_neg  (r_neg_y),
        .i_shift    (w_add_shift),
        .i_first    (w_first),
        .o_acc      (w_acc_y)
    );

    dlr_serial_acc #(.SW(SW)) u_acc_z (
        .i_clk      (i_clk),
        .i_load_acc (w_acc_load),
        .i_acc_init ({i_start_depth, {FRAC_BITS{1'b0}}}),
        .i_load_inc (w_inc_load),
        .i_inc_mag  (w_quo_z),
        .i_inc_neg  (r_neg_z),
        .i_shift    (w_add_shift),
        .i_first    (w_first),
        .o_acc      (w_acc_z)
    );

    // rounding and output register
    dlr_out_stage #(
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_out_ctrl),
        .i_acc_x     (w_acc_x),
        .i_acc_y     (w_acc_y),
        .i_acc_z     (w_acc_z),
        .i_ready     (i_ready),
        .o_free      (w_out_free),
        .o_valid     (o_valid),
        .o_valid_res (o_valid_res),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_visible   (o_visible),
        .o_red       (o_red),
        .o_last      (o_last)
    );

    // a divide or add pass always ends in the output state
    `ASSERT_NEXT(a_pass_to_out, i_clk, i_rst_n, (r_state == S_DIV || r_state == S_ADD) && r_cnt == CNT_LAST, r_state == S_OUT)

    // an advance on an active line uses up exactly one step
    `ASSERT_NEXT(a_step_count, i_clk, i_rst_n, w_in_xfer && i_opcode == OP_STEP && r_steps_left != '0, r_steps_left == $past(r_steps_left) - COORD_W'(1))

    // the final pixel leaves no line active
    `ASSERT_IMPL(a_last_clears, i_clk, i_rst_n, w_out_ctrl.load && r_last, r_steps_left == '0)

    // a result is only loaded into a free output register
    `ASSERT_IMPL(a_out_free, i_clk, i_rst_n, w_out_ctrl.load, !o_valid || i_ready)

endmodule

// ----- hdl/dlr_serial_div.sv -----
// ----------------------------------------------------------------------------
// dlr_serial_div
// bit-serial restoring divider, one quotient bit per cycle while i_shift is high
// ----------------------------------------------------------------------------
module dlr_serial_div
    import dlr_pkg::*;
#(
    parameter int SW = FRAC_BITS_DEF + DEPTH_W
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_shift,
    input  logic [SW-1:0]      i_dividend,
    input  logic [COORD_W-1:0] i_divisor,
    output logic [SW-1:0]      o_quotient
);

    logic [COORD_W-1:0] r_rem;
    logic [SW-1:0]      r_quo;
    logic [COORD_W:0]   w_trial;
    logic [COORD_W:0]   w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[SW-1]};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_shift) begin
            // remainder stays below the divisor, so 12 bits suffice
            r_rem <= w_ge ? w_diff[COORD_W-1:0] : w_trial[COORD_W-1:0];
            r_quo <= {r_quo[SW-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;

endmodule

// ----- hdl/dlr_serial_acc.sv -----
// ----------------------------------------------------------------------------
// dlr_serial_acc
// bit-serial accumulator: adds or subtracts a stored increment lsb first
// ----------------------------------------------------------------------------
module dlr_serial_acc
    import dlr_pkg::*;
#(
    parameter int SW = FRAC_BITS_DEF + DEPTH_W
) (
    input  logic          i_clk,
    input  logic          i_load_acc,
    input  logic [SW-1:0] i_acc_init,
    input  logic          i_load_inc,
    input  logic [SW-1:0] i_inc_mag,
    input  logic          i_inc_neg,
    input  logic          i_shift,
    input  logic          i_first,
    output logic [SW-1:0] o_acc
);

    logic [SW-1:0] r_acc;
    logic [SW-1:0] r_inc;
    logic          r_neg;
    logic          r_carry;
    logic          w_b;
    logic          w_cin;
    logic          w_sum;
    logic          w_cout;

    // subtraction as addition of the inverted magnitude with carry in
    assign w_b    = r_inc[0] ^ r_neg;
    assign w_cin  = i_first ? r_neg : r_carry;
    assign w_sum  = r_acc[0] ^ w_b ^ w_cin;
    assign w_cout = (r_acc[0] & w_b) | (r_acc[0] & w_cin) | (w_b & w_cin);

    always_ff @(posedge i_clk) begin
        if (i_load_acc) begin
            r_acc <= i_acc_init;
        end else if (i_shift) begin
            r_acc   <= {w_sum, r_acc[SW-1:1]};
            r_carry <= w_cout;
        end
        if (i_load_inc) begin
            r_inc <= i_inc_mag;
            r_neg <= i_inc_neg;
        end else if (i_shift) begin
            r_inc <= {r_inc[0], r_inc[SW-1:1]};
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- hdl/dlr_out_stage.sv -----
// ----------------------------------------------------------------------------
// dlr_out_stage
// rounds the accumulators to a pixel and holds the result for transfer
// ----------------------------------------------------------------------------
module dlr_out_stage
    import dlr_pkg::*;
#(
    parameter int SCREEN_W  = SCREEN_W_DEF,
    parameter int SCREEN_H  = SCREEN_H_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SW        = FRAC_BITS + DEPTH_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_out_ctrl          i_ctrl,
    input  logic [SW-1:0]      i_acc_x,
    input  logic [SW-1:0]      i_acc_y,
    input  logic [SW-1:0]      i_acc_z,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output logic               o_valid_res,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic               o_visible,
    output logic [RED_W-1:0]   o_red,
    output logic               o_last
);

    localparam int XW = COORD_W + 1 + FRAC_BITS;
    localparam int ZF = FRAC_BITS + DEPTH_FRAC;
    localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);

    logic               r_valid;
    logic               r_valid_res;
    logic [COORD_W-1:0] r_pixel_x;
    logic [COORD_W-1:0] r_pixel_y;
    logic               r_visible;
    logic [RED_W-1:0]   r_red;
    logic               r_last;

    logic [XW-1:0]      w_sx;
    logic [XW-1:0]      w_sy;
    logic [COORD_W:0]   w_px;
    logic [COORD_W:0]   w_py;
    logic [RED_W-1:0]   w_zi;
    logic               w_vis;

    // truncation toward zero: floor plus one for a negative with a fraction
    assign w_sx = i_acc_x[XW-1:0] + HALF;
    assign w_sy = i_acc_y[XW-1:0] + HALF;
    assign w_px = w_sx[XW-1:FRAC_BITS]
                + (COORD_W+1)'(w_sx[XW-1] && (|w_sx[FRAC_BITS-1:0]));
    assign w_py = w_sy[XW-1:FRAC_BITS]
                + (COORD_W+1)'(w_sy[XW-1] && (|w_sy[FRAC_BITS-1:0]));
    assign w_zi = i_acc_z[ZF+RED_W-1:ZF]
                + RED_W'(i_acc_z[SW-1] && (|i_acc_z[ZF-1:0]));
    assign w_vis = !w_px[COORD_W] && (w_px < (COORD_W+1)'(SCREEN_W))
                && !w_py[COORD_W] && (w_py < (COORD_W+1)'(SCREEN_H));

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            if (i_ctrl.none) begin
                r_valid_res <= 1'b0;
                r_pixel_x   <= '0;
                r_pixel_y   <= '0;
                r_visible   <= 1'b0;
                r_red       <= '0;
                r_last      <= 1'b0;
            end else begin
                r_valid_res <= 1'b1;
                r_pixel_x   <= w_px[COORD_W-1:0];
                r_pixel_y   <= w_py[COORD_W-1:0];
                r_visible   <= w_vis;
                r_red       <= i_ctrl.shade ? w_zi : '0;
                r_last      <= i_ctrl.last;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_valid_res = r_valid_res;
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_visible   = r_visible;
    assign o_red       = r_red;
    assign o_last      = r_last;

endmodule
